### hdl/crcpf_pkg.sv
// Shared types and constants for the CRC16 packet framer.
`default_nettype none

package crcpf_pkg;

   localparam logic [7:0]  SOF_HI_BYTE   = 8'hAA;
   localparam logic [7:0]  SOF_LO_BYTE   = 8'h55;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam int          HEADER_BYTES  = 14;
   localparam int          HDR_IDX_W     = $clog2(HEADER_BYTES);
   localparam logic [7:0]  VERSION_RESET = 8'h01;

   // Header byte positions
   localparam logic [HDR_IDX_W-1:0] HDR_SOF_HI  = HDR_IDX_W'(0);
   localparam logic [HDR_IDX_W-1:0] HDR_SOF_LO  = HDR_IDX_W'(1);
   localparam logic [HDR_IDX_W-1:0] HDR_VERSION = HDR_IDX_W'(2);
   localparam logic [HDR_IDX_W-1:0] HDR_TYPE    = HDR_IDX_W'(3);
   localparam logic [HDR_IDX_W-1:0] HDR_LEN0    = HDR_IDX_W'(4);
   localparam logic [HDR_IDX_W-1:0] HDR_LEN1    = HDR_IDX_W'(5);
   localparam logic [HDR_IDX_W-1:0] HDR_SEQ0    = HDR_IDX_W'(6);
   localparam logic [HDR_IDX_W-1:0] HDR_SEQ1    = HDR_IDX_W'(7);
   localparam logic [HDR_IDX_W-1:0] HDR_SEQ2    = HDR_IDX_W'(8);
   localparam logic [HDR_IDX_W-1:0] HDR_SEQ3    = HDR_IDX_W'(9);
   localparam logic [HDR_IDX_W-1:0] HDR_TIM0    = HDR_IDX_W'(10);
   localparam logic [HDR_IDX_W-1:0] HDR_TIM1    = HDR_IDX_W'(11);
   localparam logic [HDR_IDX_W-1:0] HDR_TIM2    = HDR_IDX_W'(12);
   localparam logic [HDR_IDX_W-1:0] HDR_TIM3    = HDR_IDX_W'(13);

   // One classified item as it travels from front to back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first;
      logic        last;
      logic [7:0]  version_byte;
      logic [7:0]  pkt_type;
      logic [15:0] pkt_len;
      logic [31:0] seq_number;
      logic [31:0] time_stamp;
   } crcpf_cmd_type;

   typedef enum logic [1:0] {
      PH_HDR,
      PH_DATA,
      PH_CRC_LO,
      PH_CRC_HI
   } crcpf_phase_type;

endpackage

`default_nettype wire

### hdl/crcpf_front.sv
// Front end: accepts items, tracks packet position, builds commands.
`default_nettype none

module crcpf_front
   import crcpf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [7:0]    csr_wr_data,
   input  wire logic          accept,
   input  wire logic [7:0]    data_byte,
   input  wire logic [15:0]   pkt_len,
   input  wire logic [7:0]    pkt_type,
   input  wire logic [31:0]   seq_number,
   input  wire logic [31:0]   time_stamp,
   output crcpf_cmd_type      cmd
);

   logic        in_packet_ff, in_packet_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  version_ff;
   logic [15:0] left_now;
   logic        first_now;
   logic        last_now;

   always_comb begin
      first_now = !in_packet_ff;
      if (first_now) begin
         // zero length closes after one byte
         left_now = (pkt_len == 16'd0) ? 16'd1 : pkt_len;
      end else begin
         left_now = bytes_left_ff;
      end
      last_now      = (left_now == 16'd1);
      bytes_left_in = left_now - 16'd1;
      in_packet_in  = !last_now;
   end

   always_comb begin
      cmd.data_byte    = data_byte;
      cmd.first        = first_now;
      cmd.last         = last_now;
      cmd.version_byte = version_ff;
      cmd.pkt_type     = pkt_type;
      cmd.pkt_len      = pkt_len;
      cmd.seq_number   = seq_number;
      cmd.time_stamp   = time_stamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff  <= 1'b0;
         bytes_left_ff <= 16'd0;
         version_ff    <= VERSION_RESET;
      end else begin
         if (accept) begin
            in_packet_ff  <= in_packet_in;
            bytes_left_ff <= bytes_left_in;
         end
         if (csr_wr_en) begin
            version_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/crcpf_queue.sv
// Short command queue between front and back.
`default_nettype none

module crcpf_queue
   import crcpf_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire crcpf_cmd_type wr_cmd,
   output logic         full,
   input  wire logic    rd_en,
   output crcpf_cmd_type rd_cmd,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   crcpf_cmd_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hdl/crcpf_back.sv
// Back end: byte sequencer, running CRC and output register.
`default_nettype none

module crcpf_back
   import crcpf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire crcpf_cmd_type cmd,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   output logic         empty,
   input  wire logic    pop,
   output logic [7:0]   out_byte,
   output logic         end_of_run,
   output logic         end_of_frame
);

   function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   crcpf_phase_type      phase_ff, phase_in, cur_phase;
   logic                 mid_ff, mid_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in, cur_idx;
   logic [15:0]          crc_ff;
   logic                 fire;
   logic                 done;
   logic [7:0]           byte_sel;
   logic [7:0]           hdr_byte;

   logic                 out_valid_ff;
   logic [7:0]           out_byte_ff;
   logic                 out_eor_ff;
   logic                 out_eof_ff;

   // Position within the head command; a fresh command starts at header or data
   always_comb begin
      if (mid_ff) begin
         cur_phase = phase_ff;
         cur_idx   = idx_ff;
      end else begin
         cur_phase = cmd.first ? PH_HDR : PH_DATA;
         cur_idx   = '0;
      end
   end

   assign fire = !cmd_empty && (!out_valid_ff || pop);

   always_comb begin
      unique case (cur_idx)
         HDR_SOF_HI:  hdr_byte = SOF_HI_BYTE;
         HDR_SOF_LO:  hdr_byte = SOF_LO_BYTE;
         HDR_VERSION: hdr_byte = cmd.version_byte;
         HDR_TYPE:    hdr_byte = cmd.pkt_type;
         HDR_LEN0:    hdr_byte = cmd.pkt_len[7:0];
         HDR_LEN1:    hdr_byte = cmd.pkt_len[15:8];
         HDR_SEQ0:    hdr_byte = cmd.seq_number[7:0];
         HDR_SEQ1:    hdr_byte = cmd.seq_number[15:8];
         HDR_SEQ2:    hdr_byte = cmd.seq_number[23:16];
         HDR_SEQ3:    hdr_byte = cmd.seq_number[31:24];
         HDR_TIM0:    hdr_byte = cmd.time_stamp[7:0];
         HDR_TIM1:    hdr_byte = cmd.time_stamp[15:8];
         HDR_TIM2:    hdr_byte = cmd.time_stamp[23:16];
         HDR_TIM3:    hdr_byte = cmd.time_stamp[31:24];
         default:     hdr_byte = 8'h00;
      endcase
   end

   // Output decode
   always_comb begin
      done     = 1'b0;
      byte_sel = 8'h00;
      unique case (cur_phase)
         PH_HDR:    byte_sel = hdr_byte;
         PH_DATA: begin
            byte_sel = cmd.data_byte;
            done     = !cmd.last;
         end
         PH_CRC_LO: byte_sel = crc_ff[7:0];
         PH_CRC_HI: begin
            byte_sel = crc_ff[15:8];
            done     = 1'b1;
         end
         default:   byte_sel = 8'h00;
      endcase
   end

   assign cmd_pop = fire && done;

   // Next state
   always_comb begin
      mid_in   = mid_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (fire) begin
         mid_in = !done;
         idx_in = cur_idx + HDR_IDX_W'(1);
         unique case (cur_phase)
            PH_HDR:    phase_in = (cur_idx == HDR_TIM3) ? PH_DATA : PH_HDR;
            PH_DATA:   phase_in = PH_CRC_LO;
            PH_CRC_LO: phase_in = PH_CRC_HI;
            PH_CRC_HI: phase_in = PH_HDR;
            default:   phase_in = PH_HDR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff   <= 1'b0;
         phase_ff <= PH_HDR;
         idx_ff   <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         mid_ff   <= mid_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         if (fire) begin
            priority if (cur_phase == PH_HDR && cur_idx == HDR_SOF_HI) begin
               crc_ff <= CRC_INIT;
            end else if (cur_phase == PH_HDR && cur_idx == HDR_SOF_LO) begin
               crc_ff <= crc_ff;
            end else if (cur_phase == PH_HDR || cur_phase == PH_DATA) begin
               crc_ff <= crc_feed(crc_ff, byte_sel);
            end else if (cur_phase == PH_CRC_HI) begin
               crc_ff <= CRC_INIT;
            end else begin
               // low CRC byte leaves the sum as is
               crc_ff <= crc_ff;
            end
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff <= byte_sel;
         out_eor_ff  <= done;
         out_eof_ff  <= (cur_phase == PH_CRC_HI);
      end
   end

   assign empty        = !out_valid_ff;
   assign out_byte     = out_byte_ff;
   assign end_of_run   = out_eor_ff;
   assign end_of_frame = out_eof_ff;

endmodule

`default_nettype wire

### hdl/crc16_packet_framer_unit.sv
// Top level of the CRC16 packet framer.
// Path: an accepted item enters the command queue; the back end then registers its first result.
// Throughput: the byte sequencer sends one result per cycle while results are popped. A middle
// payload item gives its data byte; the first adds the header, the last adds the two CRC bytes.
// Input accepts back to back while the command queue (QUEUE_DEPTH entries) has room.
// Reset: synchronous, active high; clears queue, packet tracking and output, version to 1.
`default_nettype none

module crc16_packet_framer_unit
   import crcpf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   // input items
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [15:0] req_pkt_len,
   input  wire logic [7:0]  req_pkt_type,
   input  wire logic [31:0] req_seq_number,
   input  wire logic [31:0] req_time_stamp,
   // result items
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_end_of_run,
   output logic             rsp_end_of_frame
);

   crcpf_cmd_type front_cmd;
   crcpf_cmd_type head_cmd;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   logic          accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   // Front: classifies each item (first / last of packet) and attaches the header fields and version
   crcpf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .pkt_len     (req_pkt_len),
      .pkt_type    (req_pkt_type),
      .seq_number  (req_seq_number),
      .time_stamp  (req_time_stamp),
      .cmd         (front_cmd)
   );

   // Decouples front from the multi-byte header/CRC bursts of the back end
   crcpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept),
      .wr_cmd (front_cmd),
      .full   (q_full),
      .rd_en  (q_pop),
      .rd_cmd (head_cmd),
      .empty  (q_empty)
   );

   // Back: walks header, payload byte and CRC, one byte per cycle while results are popped
   crcpf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd          (head_cmd),
      .cmd_empty    (q_empty),
      .cmd_pop      (q_pop),
      .empty        (empty),
      .pop          (pop),
      .out_byte     (rsp_out_byte),
      .end_of_run   (rsp_end_of_run),
      .end_of_frame (rsp_end_of_frame)
   );

endmodule

`default_nettype wire

### hdl/crcpf_checker.sv
// Port-level checker for the CRC16 packet framer, bound to the top level.
`default_nettype none

module crcpf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       full,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_end_of_run,
   input wire logic       rsp_end_of_frame
);

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte)
                            && $stable(rsp_end_of_run) && $stable(rsp_end_of_frame)))
      else $error("stalled result changed");

   // Frame end is always the last result of its item
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_end_of_frame) |-> rsp_end_of_run)
      else $error("end_of_frame without end_of_run");

   // Reset leaves both sides idle
   assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("not idle after reset");

   // The byte after a frame end opens the next frame with the start marker
   assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_end_of_frame) ##1 (!empty && !$past(reset)) |->
         (rsp_out_byte == 8'hAA))
      else $error("frame does not start with start marker");

endmodule

bind crc16_packet_framer_unit crcpf_checker u_crcpf_checker (
   .clock            (clock),
   .reset            (reset),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_end_of_run   (rsp_end_of_run),
   .rsp_end_of_frame (rsp_end_of_frame)
);

`default_nettype wire

### tb/tb_crc16_packet_framer_unit.sv
// Self-checking testbench for the CRC16 packet framer: directed and random byte traffic.
`timescale 1ns / 1ps

module tb_crc16_packet_framer_unit;
   import crcpf_pkg::*;

   // A run may go this many cycles with no handshake on either side.
   // The long receiver hold-off (HOLD_CYCLES) is far shorter, so this leaves a wide margin.
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 120;

   // One byte on the wire together with its two flags
   typedef struct packed {
      logic [7:0] wire_byte;
      logic       eor;
      logic       eof;
   } frame_byte_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   logic        push;
   logic        full;
   logic [7:0]  req_data_byte;
   logic [15:0] req_pkt_len;
   logic [7:0]  req_pkt_type;
   logic [31:0] req_seq_number;
   logic [31:0] req_time_stamp;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_run;
   logic        rsp_end_of_frame;

   crc16_packet_framer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .push             (push),
      .full             (full),
      .req_data_byte    (req_data_byte),
      .req_pkt_len      (req_pkt_len),
      .req_pkt_type     (req_pkt_type),
      .req_seq_number   (req_seq_number),
      .req_time_stamp   (req_time_stamp),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Framing predictor: own copy of the packet state and the version.
   // ---------------------------------------------------------------
   logic        fr_open    = 1'b0;
   logic [15:0] fr_left    = 16'd0;
   logic [15:0] fr_crc     = CRC_INIT;
   logic [7:0]  fr_version = VERSION_RESET;

   // Bytes still owed by the block, oldest first
   frame_byte_type wire_bytes_q[$];

   int err_count   = 0;
   int rsp_count   = 0;
   int items_sent  = 0;
   int idle_cycles = 0;

   // Idle controls: quiet means no gaps on that side
   bit tx_quiet      = 1'b0;
   bit rx_quiet      = 1'b0;
   int rx_hold_cycles = 0;

   // CCITT-FALSE update, MSB first, one byte
   function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  b);
      logic [15:0] c;
      c = crc_in ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   // Works out the wire bytes that one accepted item causes
   task automatic frame_item(input logic [7:0]  data,
                             input logic [15:0] len,
                             input logic [7:0]  typ,
                             input logic [31:0] seq,
                             input logic [31:0] tim);
      logic [7:0]  hdr [0:HEADER_BYTES-1];
      frame_byte_type burst[$];
      hdr[0] = SOF_HI_BYTE;
      hdr[1] = SOF_LO_BYTE;
      if (!fr_open) begin
         hdr[2] = fr_version;
         hdr[3] = typ;
         hdr[4] = len[7:0];
         hdr[5] = len[15:8];
         for (int i = 0; i < 4; i++) begin
            hdr[6 + i]  = seq[8*i +: 8];
            hdr[10 + i] = tim[8*i +: 8];
         end
         fr_crc = CRC_INIT;
         for (int i = 0; i < HEADER_BYTES; i++) begin
            burst.push_back('{hdr[i], 1'b0, 1'b0});
            // start marker stays out of the CRC
            if (i >= 2)
               fr_crc = crc_ccitt_byte(fr_crc, hdr[i]);
         end
         // zero length closes after a single byte
         fr_left = (len == 16'd0) ? 16'd1 : len;
         fr_open = 1'b1;
      end
      burst.push_back('{data, 1'b0, 1'b0});
      fr_crc  = crc_ccitt_byte(fr_crc, data);
      fr_left = fr_left - 16'd1;
      if (fr_left == 16'd0) begin
         // low CRC byte goes out first, the high one closes the frame
         burst.push_back('{fr_crc[7:0], 1'b0, 1'b0});
         burst.push_back('{fr_crc[15:8], 1'b0, 1'b1});
         fr_open = 1'b0;
         fr_crc  = CRC_INIT;
      end
      burst[burst.size() - 1].eor = 1'b1;
      foreach (burst[i])
         wire_bytes_q.push_back(burst[i]);
   endtask

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      err_count++;
      $display("%0t ns: mismatch on %s at result %0d: got %0h, expected %0h",
               $time, what, rsp_count, got, want);
   endtask

   task automatic check_result(input logic [7:0] ob, input logic eor, input logic eof);
      frame_byte_type want;
      rsp_count++;
      if (wire_bytes_q.size() == 0) begin
         report_mismatch("unexpected result", 16'(ob), 16'd0);
         return;
      end
      want = wire_bytes_q.pop_front();
      if (ob !== want.wire_byte)
         report_mismatch("out_byte", 16'(ob), 16'(want.wire_byte));
      if (eor !== want.eor)
         report_mismatch("end_of_run", 16'(eor), 16'(want.eor));
      if (eof !== want.eof)
         report_mismatch("end_of_frame", 16'(eof), 16'(want.eof));
   endtask

   // Receiver: random stall per item, or one long hold-off on request.
   // Outputs are sampled at the falling edge, where they are stable.
   initial begin
      int   stall;
      bit   got;
      logic [7:0] ob;
      logic eor;
      logic eof;
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rx_quiet ? 0 : $urandom_range(0, 11);
         if (rx_hold_cycles > 0) begin
            stall = rx_hold_cycles;
            rx_hold_cycles = 0;
         end
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do begin
            @(negedge clock);
            got = !empty;
            ob  = rsp_out_byte;
            eor = rsp_end_of_run;
            eof = rsp_end_of_frame;
            @(posedge clock);
         end while (!got);
         check_result(ob, eor, eof);
      end
   end

   // Watchdog: counts cycles without any handshake
   always @(negedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d bytes still owed",
                  $time, IDLE_LIMIT, wire_bytes_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------
   // Called just after a rising edge; returns at the edge that took the item,
   // with push still high so a back-to-back item needs no second assignment.
   task automatic send_item(input logic [7:0]  data,
                            input logic [15:0] len,
                            input logic [7:0]  typ,
                            input logic [31:0] seq,
                            input logic [31:0] tim);
      int gap;
      bit taken;
      gap = tx_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push            <= 1'b1;
      req_data_byte   <= data;
      req_pkt_len     <= len;
      req_pkt_type    <= typ;
      req_seq_number  <= seq;
      req_time_stamp  <= tim;
      do begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end while (!taken);
      items_sent++;
      frame_item(data, len, typ, seq, tim);
   endtask

   // One packet: the first item carries the header, the rest carry noise
   // in the header fields, which the block must ignore.
   task automatic send_packet(input logic [15:0] len, input logic [7:0] typ,
                              input logic [31:0] seq, input logic [31:0] tim,
                              input int count);
      send_item(8'($urandom_range(0, 255)), len, typ, seq, tim);
      for (int i = 1; i < count; i++)
         send_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), $urandom, $urandom);
   endtask

   // Sender pauses until every owed byte has come out
   task automatic drain_results();
      push <= 1'b0;
      while (wire_bytes_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_version(input logic [7:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      fr_version = v;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return 16'd0;
      if (r < 3)
         return 16'($urandom_range(7, 40));
      return 16'($urandom_range(1, 6));
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Version after reset, data and header extremes on one-byte packets
   task automatic test_single_byte_packets();
      send_item(8'h00, 16'd1, 8'h00, 32'h0000_0000, 32'h0000_0000);
      send_item(8'hFF, 16'd1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(8'hA5, 16'd1, 8'h5A, 32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // Length zero goes into the header as is but closes after one byte
   task automatic test_zero_length();
      send_item(8'h3C, 16'd0, 8'h81, 32'h1234_5678, 32'h9ABC_DEF0);
      send_item(8'hC3, 16'd0, 8'h7E, 32'h0000_0001, 32'h8000_0000);
   endtask

   // Continuation items carry changing header fields that must not leak
   task automatic test_multi_byte();
      send_item(8'h00, 16'd3, 8'h01, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(8'hFF, 16'd1, 8'hEE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(8'h80, 16'd0, 8'h00, 32'h5555_5555, 32'hAAAA_AAAA);
      send_packet(16'd2, 8'h42, $urandom, $urandom, 2);
   endtask

   // Register extremes and a random value, each followed by a packet using it
   task automatic test_version_register();
      write_version(8'h00);
      send_packet(16'd2, 8'h10, $urandom, $urandom, 2);
      write_version(8'hFF);
      send_packet(16'd1, 8'h20, $urandom, $urandom, 1);
      write_version(8'($urandom_range(0, 255)));
      send_packet(16'd1, 8'h30, $urandom, $urandom, 1);
      // write while idle inside a packet: the open packet keeps its header
      send_item(8'h11, 16'd2, 8'h40, $urandom, $urandom);
      write_version(8'h5A);
      send_item(8'h22, 16'd9, 8'h41, $urandom, $urandom);
      send_packet(16'd1, 8'h42, $urandom, $urandom, 1);
   endtask

   // Receiver stops for a long time while the sender keeps pushing,
   // so the command queue fills and full must hold the sender off
   task automatic test_backpressure();
      drain_results();
      tx_quiet = 1'b1;
      rx_hold_cycles = HOLD_CYCLES;
      send_packet(16'd20, 8'($urandom_range(0, 255)), $urandom, $urandom, 20);
      send_packet(16'd1, 8'($urandom_range(0, 255)), $urandom, $urandom, 1);
      tx_quiet = 1'b0;
      drain_results();
      // back to back on both sides
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      send_packet(16'd5, 8'($urandom_range(0, 255)), $urandom, $urandom, 5);
      send_packet(16'd1, 8'($urandom_range(0, 255)), $urandom, $urandom, 1);
      drain_results();
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   // Well-formed packets of random content and length, with
   // version changes and stretches without idling on either side
   task automatic test_random_traffic();
      logic [15:0] len;
      int          start;
      int          r;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            write_version(8'h00);
         else if (r == 1)
            write_version(8'hFF);
         else if (r == 2)
            write_version(8'($urandom_range(0, 255)));
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         len = pick_len();
         send_packet(len, 8'($urandom_range(0, 255)), $urandom, $urandom,
                     (len == 16'd0) ? 1 : int'(len));
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   // Maximum length in the header; the packet is left open at the end
   task automatic test_max_length_header();
      drain_results();
      send_item(8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(8'h00, 16'h0000, 8'h00, 32'h0000_0000, 32'h0000_0000);
      send_item(8'h7F, 16'h8000, 8'h80, $urandom, $urandom);
   endtask

   initial begin
      reset           <= 1'b1;
      push            <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= 8'h00;
      req_data_byte   <= 8'h00;
      req_pkt_len     <= 16'h0000;
      req_pkt_type    <= 8'h00;
      req_seq_number  <= 32'h0;
      req_time_stamp  <= 32'h0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_byte_packets();
      test_zero_length();
      test_multi_byte();
      test_version_register();
      test_backpressure();
      test_random_traffic();
      test_max_length_header();

      drain_results();
      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
